/* src/pulse_period_slip_detector_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef PULSE_PERIOD_SLIP_DETECTOR_MACROS_SVH
`define PULSE_PERIOD_SLIP_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PPSD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ppsd_pkg.sv */
package ppsd_pkg;

   localparam int RING_DEPTH_DEF  = 24;
   localparam int PERIOD_BITS_DEF = 16;
   localparam int AVG_BITS        = 18;
   localparam int THR_BITS        = 9;
   localparam int LIM_BITS        = 16;
   localparam int CSR_ADDR_BITS   = 5;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [AVG_BITS-1:0] AVG_MAX = '1;

   localparam logic [THR_BITS-1:0] SLIP_RESET       = 9'd366;
   localparam logic [THR_BITS-1:0] TREND_RESET      = 9'd287;
   localparam logic [LIM_BITS-1:0] LOW_RESET        = 16'd6000;
   localparam logic [LIM_BITS-1:0] HIGH_RESET       = 16'd10000;
   localparam logic [AVG_BITS-1:0] STOP_LIMIT_RESET = 18'd30000;
   localparam logic [LIM_BITS-1:0] BASE_TO_RESET    = 16'd20000;
   localparam logic [LIM_BITS-1:0] RUN_TO_RESET     = 16'd65500;

   localparam logic [2:0] REG_SLIP       = 3'd0;
   localparam logic [2:0] REG_TREND      = 3'd1;
   localparam logic [2:0] REG_LOW        = 3'd2;
   localparam logic [2:0] REG_HIGH       = 3'd3;
   localparam logic [2:0] REG_STOP_LIMIT = 3'd4;
   localparam logic [2:0] REG_BASE_TO    = 3'd5;
   localparam logic [2:0] REG_RUN_TO     = 3'd6;

   typedef enum logic [2:0] {
      OP_CLEAR         = 3'd0,
      OP_BASE_PULSE    = 3'd1,
      OP_BASE_TIMEOUT  = 3'd2,
      OP_ENTER_RUN     = 3'd3,
      OP_RUN_PULSE     = 3'd4,
      OP_RUN_POLL      = 3'd5,
      OP_RUN_OVERFLOW  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_WINDOW  = 2'd1,
      CAUSE_TREND   = 2'd2,
      CAUSE_AVERAGE = 2'd3
   } cause_type;

   // Shared multiplier schedule for the run checks.
   typedef enum logic [2:0] {
      STEP_SLIP_AVG  = 3'd0,
      STEP_SLIP_B2   = 3'd1,
      STEP_L0_B1     = 3'd2,
      STEP_L1_B0     = 3'd3,
      STEP_TREND_B1  = 3'd4,
      STEP_TREND_B0  = 3'd5,
      STEP_LAST_EVAL = 3'd6,
      STEP_APPLY     = 3'd7
   } step_type;

   typedef struct packed {
      logic [THR_BITS-1:0] slip;
      logic [THR_BITS-1:0] trend;
      logic [LIM_BITS-1:0] low;
      logic [LIM_BITS-1:0] high;
      logic [AVG_BITS-1:0] stop_limit;
      logic [LIM_BITS-1:0] base_to;
      logic [LIM_BITS-1:0] run_to;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic       clear;
      logic       wr_base;
      logic       base_timeout;
      logic       wr_live;
      logic       live_timeout;
      logic       advance;
      logic       rd_issue;
      logic [1:0] rd_k;
      logic       walk_start;
      logic       walk_rd;
      logic       avg_load;
      logic       mul_run;
      step_type   mul_step;
      logic       apply_window;
      logic       apply_trend;
   } cmd_type;

   typedef struct packed {
      logic stopped;
   } status_type;

endpackage

/* src/ppsd_ctrl.sv */
module ppsd_ctrl #(
   parameter int RING_DEPTH = ppsd_pkg::RING_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [2:0]             req_op,
   input  ppsd_pkg::status_type   status,
   input  logic                   out_free,
   output logic                   req_stall,
   output ppsd_pkg::cmd_type      cmd,
   output logic                   load_out
);

   localparam int CW = $clog2(RING_DEPTH + 1);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_CLR  = 9'b000000010,
      S_BWR  = 9'b000000100,
      S_WALK = 9'b000001000,
      S_AVG  = 9'b000010000,
      S_LWR  = 9'b000100000,
      S_RD   = 9'b001000000,
      S_MUL  = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [2:0]     op_ff, op_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      cmd       = '0;
      req_stall = 1'b1;
      load_out  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = req_op;
               cnt_in      = '0;
               unique case (req_op)
                  ppsd_pkg::OP_CLEAR: state_in = S_CLR;
                  ppsd_pkg::OP_BASE_PULSE,
                  ppsd_pkg::OP_BASE_TIMEOUT: state_in = S_BWR;
                  ppsd_pkg::OP_ENTER_RUN: begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
                  ppsd_pkg::OP_RUN_PULSE,
                  ppsd_pkg::OP_RUN_POLL,
                  ppsd_pkg::OP_RUN_OVERFLOW: state_in = status.stopped ? S_DONE : S_LWR;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_CLR: begin
            cmd.clear = 1'b1;
            state_in  = S_DONE;
         end
         S_BWR: begin
            cmd.wr_base      = 1'b1;
            cmd.base_timeout = (op_ff == ppsd_pkg::OP_BASE_TIMEOUT);
            cmd.advance      = 1'b1;
            state_in         = S_DONE;
         end
         S_WALK: begin
            if (cnt_ff == CW'(RING_DEPTH)) begin
               state_in = S_AVG;
            end else begin
               cmd.walk_rd = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end
         end
         S_AVG: begin
            cmd.avg_load = 1'b1;
            state_in     = S_DONE;
         end
         S_LWR: begin
            cmd.wr_live      = 1'b1;
            cmd.live_timeout = (op_ff == ppsd_pkg::OP_RUN_OVERFLOW);
            cmd.advance      = (op_ff != ppsd_pkg::OP_RUN_POLL);
            state_in         = (op_ff == ppsd_pkg::OP_RUN_OVERFLOW) ? S_DONE : S_RD;
         end
         S_RD: begin
            if (cnt_ff == CW'(3)) begin
               cnt_in   = '0;
               state_in = S_MUL;
            end else begin
               cmd.rd_issue = 1'b1;
               cmd.rd_k     = cnt_ff[1:0];
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         S_MUL: begin
            cmd.mul_run  = 1'b1;
            cmd.mul_step = ppsd_pkg::step_type'(cnt_ff[2:0]);
            if (cmd.mul_step == ppsd_pkg::STEP_APPLY) begin
               cmd.apply_window = 1'b1;
               cmd.apply_trend  = (op_ff == ppsd_pkg::OP_RUN_PULSE);
               state_in         = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         op_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         op_ff    <= op_in;
      end
   end

endmodule

/* src/ppsd_datapath.sv */
module ppsd_datapath #(
   parameter int RING_DEPTH  = ppsd_pkg::RING_DEPTH_DEF,
   parameter int PERIOD_BITS = ppsd_pkg::PERIOD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ppsd_pkg::cmd_type                cmd,
   input  ppsd_pkg::cfg_type                cfg,
   input  logic [PERIOD_BITS-1:0]           req_period,
   output ppsd_pkg::status_type             status,
   output logic                             stopped,
   output logic [1:0]                       stop_cause,
   output logic                             baseline_fault,
   output logic [ppsd_pkg::AVG_BITS-1:0]    baseline_average
);

   localparam int AB   = ppsd_pkg::AVG_BITS;
   localparam int IW   = $clog2(RING_DEPTH);
   localparam int SW   = PERIOD_BITS + $clog2(RING_DEPTH);
   localparam int EW   = (SW > AB + 3) ? SW : AB + 3;
   localparam int MW   = (PERIOD_BITS > AB) ? PERIOD_BITS : AB;
   localparam int PW   = 2 * MW;
   localparam int CMPW = (PERIOD_BITS > ppsd_pkg::LIM_BITS) ? PERIOD_BITS : ppsd_pkg::LIM_BITS;
   localparam int WSW  = PERIOD_BITS + 2;

   logic [PERIOD_BITS-1:0] base_mem [RING_DEPTH];
   logic [PERIOD_BITS-1:0] live_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0]  base_vld_ff, live_vld_ff;

   logic [PERIOD_BITS-1:0] period_ff;
   logic [IW-1:0]          idx_ff, base_ff, walk_addr_ff;
   logic [PERIOD_BITS-1:0] b_rd_ff, l_rd_ff;
   logic                   rd_pend_ff, walk_pend_ff;
   logic [1:0]             rd_k_ff;
   logic [SW-1:0]          sum_ff;
   logic [PERIOD_BITS-1:0] win_l_ff [3];
   logic [PERIOD_BITS-1:0] win_b_ff [3];
   logic [PW-1:0]          prod_ff, cross_ff;
   logic                   win_hit_ff, trend_hit_ff;
   logic                   stop_ff, fault_ff;
   logic [1:0]             cause_ff;
   logic [AB-1:0]          avg_ff;

   logic [PERIOD_BITS-1:0] wr_data;
   logic [IW-1:0]          idx_next, back_addr, rd_addr;
   logic [IW:0]            back_wide;
   logic [WSW-1:0]         win_sum;
   logic [MW-1:0]          op_a, op_b;
   logic [EW-1:0]          avg_ext;
   logic [AB-1:0]          avg_calc;
   logic                   b_out_of_range;

   assign wr_data = cmd.wr_base ?
                    (cmd.base_timeout ? PERIOD_BITS'(cfg.base_to) : period_ff) :
                    (cmd.live_timeout ? PERIOD_BITS'(cfg.run_to) : period_ff);

   assign idx_next  = (idx_ff == IW'(RING_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
   assign back_wide = (IW+1)'(base_ff) + (IW+1)'(RING_DEPTH) - (IW+1)'(cmd.rd_k);
   assign back_addr = ((IW+1)'(base_ff) >= (IW+1)'(cmd.rd_k)) ?
                      base_ff - IW'(cmd.rd_k) : back_wide[IW-1:0];
   assign rd_addr   = cmd.walk_rd ? walk_addr_ff : back_addr;

   // Window entries: slot 0 is the newest sample, slot 2 the oldest.
   assign win_sum = WSW'(win_l_ff[0]) + WSW'(win_l_ff[1]) + WSW'(win_l_ff[2]);

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (cmd.mul_step)
         ppsd_pkg::STEP_SLIP_AVG: begin
            op_a = MW'(cfg.slip);
            op_b = MW'(avg_ff);
         end
         ppsd_pkg::STEP_SLIP_B2: begin
            op_a = MW'(cfg.slip);
            op_b = MW'(win_b_ff[0]);
         end
         ppsd_pkg::STEP_L0_B1: begin
            op_a = MW'(win_l_ff[2]);
            op_b = MW'(win_b_ff[1]);
         end
         ppsd_pkg::STEP_L1_B0: begin
            op_a = MW'(win_l_ff[1]);
            op_b = MW'(win_b_ff[2]);
         end
         ppsd_pkg::STEP_TREND_B1: begin
            op_a = MW'(cfg.trend);
            op_b = MW'(win_b_ff[1]);
         end
         ppsd_pkg::STEP_TREND_B0: begin
            op_a = MW'(cfg.trend);
            op_b = MW'(win_b_ff[2]);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign avg_ext  = EW'(sum_ff) >> 3;
   assign avg_calc = (avg_ext > EW'(ppsd_pkg::AVG_MAX)) ? ppsd_pkg::AVG_MAX : AB'(avg_ext);

   assign b_out_of_range = (CMPW'(b_rd_ff) > CMPW'(cfg.high)) ||
                           (CMPW'(b_rd_ff) < CMPW'(cfg.low));

   // Ring storage; an entry never written since clear reads as one.
   always_ff @(posedge clock) begin
      if (cmd.wr_base) begin
         base_mem[idx_ff] <= wr_data;
      end
      if (cmd.wr_live) begin
         live_mem[idx_ff] <= wr_data;
      end
      b_rd_ff <= base_vld_ff[rd_addr] ? base_mem[rd_addr] : PERIOD_BITS'(1);
      l_rd_ff <= live_vld_ff[rd_addr] ? live_mem[rd_addr] : PERIOD_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         base_vld_ff <= '0;
         live_vld_ff <= '0;
      end else begin
         if (cmd.wr_base) begin
            base_vld_ff[idx_ff] <= 1'b1;
         end
         if (cmd.wr_live) begin
            live_vld_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         walk_pend_ff <= 1'b0;
         stop_ff      <= 1'b0;
         cause_ff     <= ppsd_pkg::CAUSE_NONE;
         fault_ff     <= 1'b0;
         avg_ff       <= '0;
      end else begin
         rd_pend_ff   <= cmd.rd_issue;
         walk_pend_ff <= cmd.walk_rd;
         if (cmd.clear) begin
            idx_ff   <= '0;
            stop_ff  <= 1'b0;
            cause_ff <= ppsd_pkg::CAUSE_NONE;
            fault_ff <= 1'b0;
         end else begin
            if (cmd.advance) begin
               idx_ff <= idx_next;
            end
            if (walk_pend_ff && b_out_of_range) begin
               fault_ff <= 1'b1;
            end
            if (cmd.avg_load) begin
               avg_ff <= avg_calc;
               if (!stop_ff && (avg_calc > cfg.stop_limit)) begin
                  stop_ff  <= 1'b1;
                  cause_ff <= ppsd_pkg::CAUSE_AVERAGE;
               end
            end
            if (cmd.apply_window && !stop_ff) begin
               if (win_hit_ff) begin
                  stop_ff  <= 1'b1;
                  cause_ff <= ppsd_pkg::CAUSE_WINDOW;
               end else if (cmd.apply_trend && trend_hit_ff) begin
                  stop_ff  <= 1'b1;
                  cause_ff <= ppsd_pkg::CAUSE_TREND;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         period_ff <= req_period;
         base_ff   <= idx_ff;
      end
      rd_k_ff <= cmd.rd_k;
      if (cmd.walk_start) begin
         walk_addr_ff <= '0;
         sum_ff       <= '0;
      end else begin
         if (cmd.walk_rd) begin
            walk_addr_ff <= walk_addr_ff + 1'b1;
         end
         if (walk_pend_ff) begin
            sum_ff <= sum_ff + SW'(b_rd_ff);
         end
      end
      if (rd_pend_ff) begin
         win_l_ff[rd_k_ff] <= l_rd_ff;
         win_b_ff[rd_k_ff] <= b_rd_ff;
      end
      if (cmd.mul_run) begin
         prod_ff <= op_a * op_b;
         unique case (cmd.mul_step)
            ppsd_pkg::STEP_SLIP_B2:
               win_hit_ff <= (PW'(win_sum) > PW'(avg_ff)) &&
                             ((PW'(win_sum) << 8) >= prod_ff);
            ppsd_pkg::STEP_L0_B1:
               trend_hit_ff <= (PW'(win_l_ff[0]) << 8) >= prod_ff;
            ppsd_pkg::STEP_L1_B0:
               cross_ff <= prod_ff;
            ppsd_pkg::STEP_TREND_B1:
               trend_hit_ff <= trend_hit_ff && (prod_ff > cross_ff);
            ppsd_pkg::STEP_TREND_B0:
               trend_hit_ff <= trend_hit_ff && ((PW'(win_l_ff[1]) << 8) >= prod_ff);
            ppsd_pkg::STEP_LAST_EVAL:
               trend_hit_ff <= trend_hit_ff && ((PW'(win_l_ff[2]) << 8) >= prod_ff);
            default: ;
         endcase
      end
   end

   assign status.stopped   = stop_ff;
   assign stopped          = stop_ff;
   assign stop_cause       = cause_ff;
   assign baseline_fault   = fault_ff;
   assign baseline_average = avg_ff;

endmodule

/* src/pulse_period_slip_detector.sv */
// Beat path: clear via CLR, baseline write via BWR, stopped run ops straight to DONE, run
// overflow via LWR, enter run via WALK and AVG, run pulse or poll via LWR, RD and MUL.
// Throughput: one beat at a time; the next beat is taken the cycle after the result
// register loads, even while that result still waits downstream. Run checks share one
// multiplier over eight steps; run entry walks the baseline ring one entry per cycle.
// Reset is synchronous: rings read as one at once through per-entry valid bits.
module pulse_period_slip_detector #(
   parameter int RING_DEPTH  = ppsd_pkg::RING_DEPTH_DEF,
   parameter int PERIOD_BITS = ppsd_pkg::PERIOD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_op,
   input  logic [PERIOD_BITS-1:0]              req_period,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_stopped,
   output logic [1:0]                          rsp_stop_cause,
   output logic                                rsp_baseline_fault,
   output logic [ppsd_pkg::AVG_BITS-1:0]       rsp_baseline_average,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ppsd_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [ppsd_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [ppsd_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);

   localparam int DB = ppsd_pkg::CSR_DATA_BITS;

   ppsd_pkg::cfg_type     cfg_ff;
   ppsd_pkg::cmd_type     cmd;
   ppsd_pkg::status_type  status;
   logic                  out_free, load_out, csr_wr;
   logic [2:0]            csr_index;

   logic                  dp_stopped, dp_fault;
   logic [1:0]            dp_cause;
   logic [ppsd_pkg::AVG_BITS-1:0] dp_average;

   logic                  rsp_valid_ff;
   logic                  rsp_stopped_ff, rsp_fault_ff;
   logic [1:0]            rsp_cause_ff;
   logic [ppsd_pkg::AVG_BITS-1:0] rsp_average_ff;

   // ------------------------------------------------------------------
   // Register port: zero-wait writes, registers sit on 4-byte strides.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slip       <= ppsd_pkg::SLIP_RESET;
         cfg_ff.trend      <= ppsd_pkg::TREND_RESET;
         cfg_ff.low        <= ppsd_pkg::LOW_RESET;
         cfg_ff.high       <= ppsd_pkg::HIGH_RESET;
         cfg_ff.stop_limit <= ppsd_pkg::STOP_LIMIT_RESET;
         cfg_ff.base_to    <= ppsd_pkg::BASE_TO_RESET;
         cfg_ff.run_to     <= ppsd_pkg::RUN_TO_RESET;
      end else if (csr_wr) begin
         // Drop writes to addresses past the last register.
         case (csr_index)
            ppsd_pkg::REG_SLIP:       cfg_ff.slip       <= pwdata[ppsd_pkg::THR_BITS-1:0];
            ppsd_pkg::REG_TREND:      cfg_ff.trend      <= pwdata[ppsd_pkg::THR_BITS-1:0];
            ppsd_pkg::REG_LOW:        cfg_ff.low        <= pwdata[ppsd_pkg::LIM_BITS-1:0];
            ppsd_pkg::REG_HIGH:       cfg_ff.high       <= pwdata[ppsd_pkg::LIM_BITS-1:0];
            ppsd_pkg::REG_STOP_LIMIT: cfg_ff.stop_limit <= pwdata[ppsd_pkg::AVG_BITS-1:0];
            ppsd_pkg::REG_BASE_TO:    cfg_ff.base_to    <= pwdata[ppsd_pkg::LIM_BITS-1:0];
            ppsd_pkg::REG_RUN_TO:     cfg_ff.run_to     <= pwdata[ppsd_pkg::LIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ppsd_pkg::REG_SLIP:       prdata = DB'(cfg_ff.slip);
         ppsd_pkg::REG_TREND:      prdata = DB'(cfg_ff.trend);
         ppsd_pkg::REG_LOW:        prdata = DB'(cfg_ff.low);
         ppsd_pkg::REG_HIGH:       prdata = DB'(cfg_ff.high);
         ppsd_pkg::REG_STOP_LIMIT: prdata = DB'(cfg_ff.stop_limit);
         ppsd_pkg::REG_BASE_TO:    prdata = DB'(cfg_ff.base_to);
         ppsd_pkg::REG_RUN_TO:     prdata = DB'(cfg_ff.run_to);
         default:                  prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer and datapath.
   // ------------------------------------------------------------------
   ppsd_ctrl #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .status    (status),
      .out_free  (out_free),
      .req_stall (req_stall),
      .cmd       (cmd),
      .load_out  (load_out)
   );

   ppsd_datapath #(
      .RING_DEPTH  (RING_DEPTH),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg_ff),
      .req_period       (req_period),
      .status           (status),
      .stopped          (dp_stopped),
      .stop_cause       (dp_cause),
      .baseline_fault   (dp_fault),
      .baseline_average (dp_average)
   );

   // ------------------------------------------------------------------
   // Result register: parts the sequencer from a stalled consumer.
   // Load when empty or being drained this cycle; hold while stalled.
   // ------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_stopped_ff <= dp_stopped;
         rsp_cause_ff   <= dp_cause;
         rsp_fault_ff   <= dp_fault;
         rsp_average_ff <= dp_average;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_stopped          = rsp_stopped_ff;
   assign rsp_stop_cause       = rsp_cause_ff;
   assign rsp_baseline_fault   = rsp_fault_ff;
   assign rsp_baseline_average = rsp_average_ff;

endmodule

/* src/ppsd_checker.sv */
`include "pulse_period_slip_detector_macros.svh"

module ppsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_stopped,
   input logic [1:0] rsp_stop_cause
);

   // A result beat that is held back stays offered.
   `PPSD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result beat dropped while stalled")

   // The block works on one beat at a time: taking one closes the input.
   `PPSD_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "second beat taken while busy")

   // A cause is reported exactly when the stop is latched.
   `PPSD_ASSERT_NOW(a_cause_matches_stop, rsp_valid, rsp_stopped == (rsp_stop_cause != ppsd_pkg::CAUSE_NONE), "stop cause disagrees with stop latch")

endmodule

bind pulse_period_slip_detector ppsd_checker u_ppsd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_stopped    (rsp_stopped),
   .rsp_stop_cause (rsp_stop_cause)
);

/* tb/sv/pulse_period_slip_detector_tb.sv */
`timescale 1ns / 100ps

module pulse_period_slip_detector_tb;

   localparam int DEPTH         = ppsd_pkg::RING_DEPTH_DEF;
   localparam int PBITS         = ppsd_pkg::PERIOD_BITS_DEF;
   localparam int AVG_BITS      = ppsd_pkg::AVG_BITS;
   localparam int THR_BITS      = ppsd_pkg::THR_BITS;
   localparam int LIM_BITS      = ppsd_pkg::LIM_BITS;
   localparam int CSR_ADDR_BITS = ppsd_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS = ppsd_pkg::CSR_DATA_BITS;
   localparam int DRAIN_WAIT    = DEPTH + 16;   // longest op (run entry walk) plus margin
   localparam int WATCHDOG      = 4000;
   localparam int ITEM_GOAL     = 1550;
   // Op code seven is unused by the block: it only reports status.
   localparam logic [2:0] OP_SPARE = 3'd7;

   typedef struct packed {
      logic            stopped;
      logic [1:0]      cause;
      logic            fault;
      logic [AVG_BITS-1:0] average;
   } status_beat_type;

   typedef struct {
      logic [2:0]  op;
      logic [15:0] period;
      bit          typed;   // expectation is typed in below rather than predicted
      status_beat_type status;
   } stim_row_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [2:0] req_op;
   logic [PBITS-1:0] req_period;
   logic rsp_valid, rsp_stall;
   logic rsp_stopped;
   logic [1:0] rsp_stop_cause;
   logic rsp_baseline_fault;
   logic [AVG_BITS-1:0] rsp_baseline_average;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata, prdata;

   pulse_period_slip_detector dut (.*);

   // Predictor state: a mirror of the block's rings, index, latches and registers.
   logic [PBITS-1:0] base_ring [DEPTH];
   logic [PBITS-1:0] live_ring [DEPTH];
   int unsigned      ring_idx;
   logic [AVG_BITS-1:0] avg_mirror;
   logic             stop_mirror, fault_mirror;
   logic [1:0]       cause_mirror;
   ppsd_pkg::cfg_type cfg;

   status_beat_type pending_status[$];
   int          fail_count;
   int          beats_in, beats_out, stops_seen, phase_count;
   int          quiet_cycles;
   int unsigned send_idle_pct, recv_stall_pct;

   // Free-running clock; the one reset at the start is driven in the main initial block.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned back_idx(int unsigned n);
      return (ring_idx + DEPTH * 4 - n) % DEPTH;
   endfunction

   function automatic void fill_rings_ones();
      for (int k = 0; k < DEPTH; k++) begin
         base_ring[k] = PBITS'(1);
         live_ring[k] = PBITS'(1);
      end
   endfunction

   function automatic void latch_cause(ppsd_pkg::cause_type c);
      if (!stop_mirror) begin
         stop_mirror  = 1'b1;
         cause_mirror = c;
      end
   endfunction

   function automatic void window_test(longint unsigned s);
      longint unsigned a;
      a = 64'(avg_mirror);
      if (s > a && s * 256 >= longint'(cfg.slip) * a) latch_cause(ppsd_pkg::CAUSE_WINDOW);
   endfunction

   function automatic bit ratio_ok(int unsigned i, logic [THR_BITS-1:0] thr);
      return longint'(live_ring[i]) * 256 >= longint'(thr) * longint'(base_ring[i]);
   endfunction

   // Advance the slip detector mirror by one beat and return its status.
   function automatic status_beat_type slip_status_after(logic [2:0] op, logic [15:0] period);
      longint unsigned sum;
      int unsigned i0, i1, i2;
      status_beat_type r;
      case (op)
         ppsd_pkg::OP_CLEAR: begin
            fill_rings_ones();
            ring_idx     = 0;
            stop_mirror  = 1'b0;
            cause_mirror = ppsd_pkg::CAUSE_NONE;
            fault_mirror = 1'b0;
         end
         ppsd_pkg::OP_BASE_PULSE, ppsd_pkg::OP_BASE_TIMEOUT: begin
            base_ring[ring_idx] = (op == ppsd_pkg::OP_BASE_PULSE) ? period : cfg.base_to;
            ring_idx = (ring_idx + 1) % DEPTH;
         end
         ppsd_pkg::OP_ENTER_RUN: begin
            sum = 0;
            for (int k = 0; k < DEPTH; k++) begin
               sum += base_ring[k];
               if (base_ring[k] > cfg.high || base_ring[k] < cfg.low) fault_mirror = 1'b1;
            end
            sum = sum / 8;
            avg_mirror = (sum > ppsd_pkg::AVG_MAX) ? ppsd_pkg::AVG_MAX : sum[AVG_BITS-1:0];
            if (avg_mirror > cfg.stop_limit) latch_cause(ppsd_pkg::CAUSE_AVERAGE);
         end
         ppsd_pkg::OP_RUN_PULSE: if (!stop_mirror) begin
            live_ring[ring_idx] = period;
            ring_idx = (ring_idx + 1) % DEPTH;
            i2 = back_idx(1);
            i1 = back_idx(2);
            i0 = back_idx(3);
            window_test(longint'(live_ring[i0]) + live_ring[i1] + live_ring[i2]);
            if (ratio_ok(i2, cfg.slip)
                && longint'(live_ring[i1]) * base_ring[i0] > longint'(live_ring[i0]) * base_ring[i1]
                && ratio_ok(i1, cfg.trend) && ratio_ok(i0, cfg.trend))
               latch_cause(ppsd_pkg::CAUSE_TREND);
         end
         ppsd_pkg::OP_RUN_POLL: if (!stop_mirror) begin
            live_ring[ring_idx] = period;
            window_test(longint'(live_ring[ring_idx]) + live_ring[back_idx(1)]
                        + live_ring[back_idx(2)]);
         end
         ppsd_pkg::OP_RUN_OVERFLOW: if (!stop_mirror) begin
            live_ring[ring_idx] = cfg.run_to;
            ring_idx = (ring_idx + 1) % DEPTH;
         end
         default: ;
      endcase
      r.stopped = stop_mirror;
      r.cause   = cause_mirror;
      r.fault   = fault_mirror;
      r.average = avg_mirror;
      return r;
   endfunction

   // Drive one request beat, idling first at random; hold until accepted.
   task automatic send_beat(logic [2:0] op, logic [15:0] period, bit typed,
                            status_beat_type typed_st);
      status_beat_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_period <= period;
      do @(posedge clock); while (req_stall);
      predicted = slip_status_after(op, period);
      pending_status.push_back(typed ? typed_st : predicted);
      beats_in++;
   endtask

   // Lower valid and wait until every result is back and the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // APB write: setup cycle, access cycle, write lands at the access edge; the bus then idles.
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CSR_ADDR_BITS'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         ppsd_pkg::REG_SLIP:       cfg.slip       = value[THR_BITS-1:0];
         ppsd_pkg::REG_TREND:      cfg.trend      = value[THR_BITS-1:0];
         ppsd_pkg::REG_LOW:        cfg.low        = value[LIM_BITS-1:0];
         ppsd_pkg::REG_HIGH:       cfg.high       = value[LIM_BITS-1:0];
         ppsd_pkg::REG_STOP_LIMIT: cfg.stop_limit = value[AVG_BITS-1:0];
         ppsd_pkg::REG_BASE_TO:    cfg.base_to    = value[LIM_BITS-1:0];
         ppsd_pkg::REG_RUN_TO:     cfg.run_to     = value[LIM_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Pick a register setting per phase: minimum, maximum, reset-like or random.
   task automatic load_settings(int phase);
      case (phase % 4)
         1: begin
            csr_write(ppsd_pkg::REG_SLIP, 256);  csr_write(ppsd_pkg::REG_TREND, 256);
            csr_write(ppsd_pkg::REG_LOW, 0);     csr_write(ppsd_pkg::REG_HIGH, 0);
            csr_write(ppsd_pkg::REG_STOP_LIMIT, 0);
            csr_write(ppsd_pkg::REG_BASE_TO, 0); csr_write(ppsd_pkg::REG_RUN_TO, 0);
         end
         2: begin
            csr_write(ppsd_pkg::REG_SLIP, 511);  csr_write(ppsd_pkg::REG_TREND, 511);
            csr_write(ppsd_pkg::REG_LOW, 65535); csr_write(ppsd_pkg::REG_HIGH, 65535);
            csr_write(ppsd_pkg::REG_STOP_LIMIT, 262143);
            csr_write(ppsd_pkg::REG_BASE_TO, 65535); csr_write(ppsd_pkg::REG_RUN_TO, 65535);
         end
         3: begin
            csr_write(ppsd_pkg::REG_SLIP, 366);  csr_write(ppsd_pkg::REG_TREND, 287);
            csr_write(ppsd_pkg::REG_LOW, 6000);  csr_write(ppsd_pkg::REG_HIGH, 10000);
            csr_write(ppsd_pkg::REG_STOP_LIMIT, 30000);
            csr_write(ppsd_pkg::REG_BASE_TO, 20000); csr_write(ppsd_pkg::REG_RUN_TO, 65500);
         end
         default: begin
            csr_write(ppsd_pkg::REG_SLIP, $urandom_range(511, 256));
            csr_write(ppsd_pkg::REG_TREND, $urandom_range(511, 256));
            csr_write(ppsd_pkg::REG_LOW, $urandom_range(8000, 0));
            csr_write(ppsd_pkg::REG_HIGH, $urandom_range(65535, 8000));
            csr_write(ppsd_pkg::REG_STOP_LIMIT, $urandom_range(262143));
            csr_write(ppsd_pkg::REG_BASE_TO, $urandom_range(65535));
            csr_write(ppsd_pkg::REG_RUN_TO, $urandom_range(65535));
         end
      endcase
   endtask

   // Response side: stall at random, check every accepted beat against the oldest entry.
   always @(posedge clock) begin
      status_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (pending_status.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               want = pending_status.pop_front();
               if (rsp_stopped !== want.stopped) begin
                  $error("stopped: expected %0d got %0d", want.stopped, rsp_stopped);
                  fail_count++;
               end
               if (rsp_stop_cause !== want.cause) begin
                  $error("stop_cause: expected %0d got %0d", want.cause, rsp_stop_cause);
                  fail_count++;
               end
               if (rsp_baseline_fault !== want.fault) begin
                  $error("baseline_fault: expected %0d got %0d", want.fault, rsp_baseline_fault);
                  fail_count++;
               end
               if (rsp_baseline_average !== want.average) begin
                  $error("baseline_average: expected %0d got %0d",
                         want.average, rsp_baseline_average);
                  fail_count++;
               end
               if (rsp_stopped === 1'b1) stops_seen++;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog: count cycles with no beat moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
         $display("[pulse_period_slip_detector] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Directed table: reset status, the all-ones rings, field extremes and every op.
   stim_row_type directed [] = '{
      '{OP_SPARE,                  16'd0,     1, '{1'b0, ppsd_pkg::CAUSE_NONE,   1'b0, 18'd0}},
      '{ppsd_pkg::OP_ENTER_RUN,    16'd0,     1, '{1'b0, ppsd_pkg::CAUSE_NONE,   1'b1, 18'd3}},
      '{ppsd_pkg::OP_RUN_PULSE,    16'hFFFF,  1, '{1'b1, ppsd_pkg::CAUSE_WINDOW, 1'b1, 18'd3}},
      '{ppsd_pkg::OP_RUN_POLL,     16'd0,     1, '{1'b1, ppsd_pkg::CAUSE_WINDOW, 1'b1, 18'd3}},
      '{ppsd_pkg::OP_RUN_OVERFLOW, 16'd0,     1, '{1'b1, ppsd_pkg::CAUSE_WINDOW, 1'b1, 18'd3}},
      '{ppsd_pkg::OP_CLEAR,        16'hFFFF,  1, '{1'b0, ppsd_pkg::CAUSE_NONE,   1'b0, 18'd3}},
      '{ppsd_pkg::OP_BASE_PULSE,   16'hFFFF,  0, '0},
      '{ppsd_pkg::OP_BASE_PULSE,   16'd0,     0, '0},
      '{ppsd_pkg::OP_BASE_TIMEOUT, 16'h5555,  0, '0},
      '{ppsd_pkg::OP_BASE_PULSE,   16'd8000,  0, '0},
      '{ppsd_pkg::OP_ENTER_RUN,    16'hAAAA,  0, '0},
      '{ppsd_pkg::OP_RUN_OVERFLOW, 16'd0,     0, '0},
      '{ppsd_pkg::OP_RUN_POLL,     16'd0,     0, '0},
      '{ppsd_pkg::OP_RUN_PULSE,    16'd0,     0, '0},
      '{ppsd_pkg::OP_RUN_PULSE,    16'd40000, 0, '0},
      '{ppsd_pkg::OP_RUN_PULSE,    16'd50000, 0, '0},
      '{ppsd_pkg::OP_RUN_PULSE,    16'd60000, 0, '0},
      '{ppsd_pkg::OP_ENTER_RUN,    16'd0,     0, '0},
      '{OP_SPARE,                  16'hFFFF,  0, '0},
      '{ppsd_pkg::OP_CLEAR,        16'd0,     0, '0}
   };

   initial begin
      int unsigned level, p;
      logic [2:0]  op;
      status_beat_type none;
      none          = '0;
      fail_count    = 0;
      beats_in      = 0;
      beats_out     = 0;
      stops_seen    = 0;
      phase_count   = 0;
      send_idle_pct = 21;
      recv_stall_pct = 73;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_op     = ppsd_pkg::OP_CLEAR;
      req_period = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      cfg = '{ppsd_pkg::SLIP_RESET, ppsd_pkg::TREND_RESET, ppsd_pkg::LOW_RESET,
              ppsd_pkg::HIGH_RESET, ppsd_pkg::STOP_LIMIT_RESET,
              ppsd_pkg::BASE_TO_RESET, ppsd_pkg::RUN_TO_RESET};
      fill_rings_ones();
      ring_idx = 0; avg_mirror = '0; stop_mirror = 1'b0;
      cause_mirror = ppsd_pkg::CAUSE_NONE;
      fault_mirror = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_beat(directed[i].op, directed[i].period, directed[i].typed, directed[i].status);
      drain();

      // Random part: calibrate, enter run, then a run sequence; noise mixed in.
      while (beats_in < ITEM_GOAL) begin
         if (beats_in > ITEM_GOAL * 2 / 3) begin
            send_idle_pct = 0;  recv_stall_pct = 0;
         end else if (beats_in > ITEM_GOAL / 3) begin
            send_idle_pct = 73; recv_stall_pct = 21;
         end
         phase_count++;
         load_settings(phase_count);
         level = $urandom_range(12000, 500);
         if ($urandom_range(9) != 0) send_beat(ppsd_pkg::OP_CLEAR, 16'($urandom), 0, none);
         repeat ($urandom_range(DEPTH + 4, DEPTH - 4)) begin
            case ($urandom_range(19))
               0:       send_beat(ppsd_pkg::OP_BASE_TIMEOUT, 16'($urandom), 0, none);
               1:       send_beat(ppsd_pkg::OP_BASE_PULSE, 16'($urandom), 0, none);
               default: send_beat(ppsd_pkg::OP_BASE_PULSE,
                                  16'(level + $urandom_range(level / 8)), 0, none);
            endcase
         end
         send_beat(ppsd_pkg::OP_ENTER_RUN, 16'($urandom), 0, none);
         repeat ($urandom_range(40, 10)) begin
            p = level + $urandom_range(level / 6);
            case ($urandom_range(19))
               0, 1:  send_beat(ppsd_pkg::OP_RUN_PULSE,
                                16'((p * 2 > 65535) ? 65535 : p * 2), 0, none);
               2:     send_beat(ppsd_pkg::OP_RUN_POLL, 16'($urandom_range(p * 2)), 0, none);
               3:     send_beat(ppsd_pkg::OP_RUN_OVERFLOW, 16'($urandom), 0, none);
               4: begin
                  op = 3'($urandom_range(7));
                  send_beat(op, 16'($urandom), 0, none);
               end
               5:     send_beat(ppsd_pkg::OP_ENTER_RUN, 16'($urandom), 0, none);
               default: send_beat(ppsd_pkg::OP_RUN_PULSE, 16'(p), 0, none);
            endcase
         end
         drain();
      end

      $display("Sent %0d request beats over %0d register phases; %0d results checked,",
               beats_in, phase_count, beats_out);
      $display("%0d of them with the stop latched.", stops_seen);
      if (fail_count == 0) begin
         $display("[pulse_period_slip_detector] OK");
      end else begin
         $display("[pulse_period_slip_detector] ERROR");
      end
      $finish;
   end

endmodule
